[sv/cgg_pkg.sv]
// shared types, constants and helpers for the curvilinear grid gradient block
package cgg_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 6;
  localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int DATA_W   = 32;
  localparam int STEN_W   = 35;
  localparam int HALF_W   = 18;
  localparam int PP_W     = STEN_W + HALF_W;
  localparam int ACC_W    = 72;
  localparam int FRAC_W   = 16;
  localparam int DIV_W    = ACC_W + FRAC_W;

  localparam logic REG_COL_INTERVALS = 1'b0;
  localparam logic REG_ROW_INTERVALS = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_SINGULAR = 1'b1;

  // stencil tap weights
  typedef enum logic [2:0] {
    CF_ZERO, CF_POS1, CF_NEG1, CF_POS3, CF_NEG3, CF_POS4, CF_NEG4
  } coef_t;

  // accumulation targets of the shared multiplier
  typedef enum logic [1:0] {
    ACC_DET, ACC_NUMX, ACC_NUMY
  } acc_sel_t;

  // control between sequencer and divider
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  // interval count held to the legal range
  function automatic logic [IDX_W-1:0] clamp_n(input logic [CFG_W-1:0] v, input int maxn);
    logic [IDX_W-1:0] r;
    if (v < CFG_W'(2)) r = IDX_W'(2);
    else if (int'(v) > maxn) r = IDX_W'(maxn);
    else r = IDX_W'(v);
    return r;
  endfunction

  // small constant weight times a sample
  function automatic logic signed [STEN_W-1:0] scale(input logic signed [DATA_W-1:0] v,
                                                     input coef_t k);
    logic signed [STEN_W-1:0] e;
    logic signed [STEN_W-1:0] r;
    e = STEN_W'(v);
    case (k)
      CF_POS1: r = e;
      CF_NEG1: r = -e;
      CF_POS3: r = e + (e <<< 1);
      CF_NEG3: r = -(e + (e <<< 1));
      CF_POS4: r = e <<< 2;
      CF_NEG4: r = -(e <<< 2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/cgg_if.sv]
// request and response channel interfaces
interface cgg_req_if;
  import cgg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] coord_x;
  logic signed [DATA_W-1:0] coord_y;
  logic signed [DATA_W-1:0] sample;
  modport source (output valid, opcode, row, col, coord_x, coord_y, sample, input ready);
  modport sink (input valid, opcode, row, col, coord_x, coord_y, sample, output ready);
endinterface

interface cgg_rsp_if;
  import cgg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] grad_x;
  logic signed [DATA_W-1:0] grad_y;
  logic                     status;
  modport source (output valid, grad_x, grad_y, status, input ready);
  modport sink (input valid, grad_x, grad_y, status, output ready);
endinterface

[sv/cgg_ram.sv]
// generic single port ram with registered read
module cgg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/cgg_div.sv]
// restoring divider, one quotient bit per cycle, rounded and saturated to q16.16
module cgg_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [cgg_pkg::ACC_W-1:0] num,
  input  logic signed [cgg_pkg::ACC_W-1:0] den,
  output logic                     done,
  output logic signed [cgg_pkg::DATA_W-1:0] quot
);
  import cgg_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } dv_state_t;

  localparam int CNT_W = $clog2(DIV_W + 1);

  dv_state_t        state;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] n;
  logic [DIV_W-1:0] q;
  logic [ACC_W-1:0] r;
  logic [ACC_W-1:0] d;
  logic             neg;
  logic [ACC_W:0]   r_sh;
  logic [ACC_W:0]   r_dif;
  logic [ACC_W:0]   r_dbl;
  logic [DIV_W-1:0] q_rnd;
  logic [DIV_W-1:0] limit;
  logic [DATA_W-1:0] mag;

  // shift in one numerator bit and try the subtract
  assign r_sh  = {r, n[DIV_W-1]};
  assign r_dif = r_sh - {1'b0, d};
  assign r_dbl = {r, 1'b0};
  assign q_rnd = q + DIV_W'(r_dbl >= {1'b0, d});
  assign limit = neg ? DIV_W'(33'h080000000) : DIV_W'(33'h07fffffff);
  assign mag   = (q_rnd > limit) ? limit[DATA_W-1:0] : q_rnd[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (cnt == CNT_W'(DIV_W - 1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          state <= DV_IDLE;
          done  <= 1'b1;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          neg <= num[ACC_W-1] ^ den[ACC_W-1];
          n   <= {(num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num)), FRAC_W'(0)};
          d   <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
          r   <= '0;
          q   <= '0;
          cnt <= '0;
        end
      end
      DV_RUN: begin
        n   <= n << 1;
        cnt <= cnt + CNT_W'(1);
        if (!r_dif[ACC_W]) begin
          r <= r_dif[ACC_W-1:0];
          q <= {q[DIV_W-2:0], 1'b1};
        end else begin
          r <= r_sh[ACC_W-1:0];
          q <= {q[DIV_W-2:0], 1'b0};
        end
      end
      DV_FIN: begin
        quot <= neg ? DATA_W'(-mag) : DATA_W'(mag);
      end
      default: ;
    endcase
  end
endmodule

[sv/curvilinear_grid_gradient.sv]
// top level: grid stores, stencil sequencer, shared multiplier and divider
//
//  channel   dir   handshake      payload
//  req       in    valid/ready    opcode, row, col, coord_x, coord_y, sample
//  rsp       out   valid/ready    grad_x, grad_y, status
//  wr        in    wr_en          wr_index, wr_data
//
// a write does not hold the block; a query holds it after its transaction through the six
// neighbour reads on the single-port stores, the multiply steps on the shared 35x18
// multiplier, the determinant check, two runs of the bit-serial divider and a load step.
// a singular query skips the divider.
// reset is synchronous and clears control state only; stores are undefined.
// a finished result waits until the output register is free; req.ready stays low until it moves there.
module curvilinear_grid_gradient (
  input  logic                        clk,
  input  logic                        rst,
  cgg_req_if.sink                     req,
  cgg_rsp_if.source                   rsp,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [cgg_pkg::CFG_W-1:0]   wr_data
);
  import cgg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_DIVX  = 7'b0010000,
    S_DIVY  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] col_intervals;
  logic [CFG_W-1:0] row_intervals;
  logic [IDX_W-1:0] nx;
  logic [IDX_W-1:0] ny;
  logic [IDX_W-1:0] r_q;
  logic [IDX_W-1:0] c_q;

  logic             accept;
  logic [2:0]       t;
  logic [3:0]       ms;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_intervals <= CFG_W'(63);
      row_intervals <= CFG_W'(63);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COL_INTERVALS: col_intervals <= wr_data;
        REG_ROW_INTERVALS: row_intervals <= wr_data;
        default: ;
      endcase
    end
  end

  assign nx = clamp_n(col_intervals, MAX_COLS - 1);
  assign ny = clamp_n(row_intervals, MAX_ROWS - 1);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // neighbour tap address and weight
  logic             axis;
  logic [1:0]       j;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] npos;
  logic [IDX_W-1:0] lim;
  coef_t            coef;
  logic [IDX_W-1:0] row_a;
  logic [IDX_W-1:0] col_a;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] addr;
  logic             we;

  always_comb begin
    axis = (t >= 3'd3);
    j    = axis ? 2'(t - 3'd3) : t[1:0];
    pos  = axis ? r_q : c_q;
    lim  = axis ? ny : nx;
    if (pos == '0) begin
      npos = pos + IDX_W'(j);
      case (j)
        2'd0:    coef = CF_NEG3;
        2'd1:    coef = CF_POS4;
        default: coef = CF_NEG1;
      endcase
    end else if (pos == lim) begin
      npos = pos - IDX_W'(j);
      case (j)
        2'd0:    coef = CF_POS3;
        2'd1:    coef = CF_NEG4;
        default: coef = CF_POS1;
      endcase
    end else begin
      case (j)
        2'd0:    begin npos = pos + IDX_W'(1); coef = CF_POS1; end
        2'd1:    begin npos = pos - IDX_W'(1); coef = CF_NEG1; end
        default: begin npos = pos;             coef = CF_ZERO; end
      endcase
    end
    row_a = axis ? npos : r_q;
    col_a = axis ? c_q : npos;
  end

  assign rd_addr = ADDR_W'(ADDR_W'(row_a) * ADDR_W'(MAX_COLS) + ADDR_W'(col_a));
  assign we      = accept && (req.opcode == OP_WRITE) &&
                   (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
  assign addr    = (state == S_IDLE) ?
                   ADDR_W'(ADDR_W'(req.row) * ADDR_W'(MAX_COLS) + ADDR_W'(req.col)) : rd_addr;

  // grid stores
  logic [DATA_W-1:0] x_rd;
  logic [DATA_W-1:0] y_rd;
  logic [DATA_W-1:0] f_rd;

  cgg_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_x_store (
    .clk(clk), .we(we), .addr(addr), .wdata(req.coord_x), .rdata(x_rd)
  );
  cgg_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_y_store (
    .clk(clk), .we(we), .addr(addr), .wdata(req.coord_y), .rdata(y_rd)
  );
  cgg_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_field_store (
    .clk(clk), .we(we), .addr(addr), .wdata(req.sample), .rdata(f_rd)
  );

  // read pipeline tags
  logic  rd_valid;
  logic  rd_axis;
  coef_t rd_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ) && (t < 3'd6);
    end
  end

  always_ff @(posedge clk) begin
    rd_axis <= axis;
    rd_coef <= coef;
  end

  // stencil sums
  logic signed [STEN_W-1:0] s_fx, s_fe, s_xx, s_xe, s_yx, s_ye;

  always_ff @(posedge clk) begin
    if (accept) begin
      s_fx <= '0; s_fe <= '0; s_xx <= '0;
      s_xe <= '0; s_yx <= '0; s_ye <= '0;
    end else if (rd_valid) begin
      if (rd_axis) begin
        s_fe <= s_fe + scale(f_rd, rd_coef);
        s_xe <= s_xe + scale(x_rd, rd_coef);
        s_ye <= s_ye + scale(y_rd, rd_coef);
      end else begin
        s_fx <= s_fx + scale(f_rd, rd_coef);
        s_xx <= s_xx + scale(x_rd, rd_coef);
        s_yx <= s_yx + scale(y_rd, rd_coef);
      end
    end
  end

  // shared multiplier operand selection
  logic signed [STEN_W-1:0] op_a;
  logic signed [STEN_W-1:0] op_b;
  logic                     op_neg;
  acc_sel_t                 op_sel;
  logic [STEN_W-1:0]        a_mag;
  logic [STEN_W-1:0]        b_mag;
  logic [HALF_W-1:0]        b_part;

  always_comb begin
    case (ms[3:1])
      3'd0:    begin op_a = s_xx; op_b = s_ye; op_neg = 1'b0; op_sel = ACC_DET;  end
      3'd1:    begin op_a = s_yx; op_b = s_xe; op_neg = 1'b1; op_sel = ACC_DET;  end
      3'd2:    begin op_a = s_fx; op_b = s_ye; op_neg = 1'b0; op_sel = ACC_NUMX; end
      3'd3:    begin op_a = s_fe; op_b = s_yx; op_neg = 1'b1; op_sel = ACC_NUMX; end
      3'd4:    begin op_a = s_fe; op_b = s_xx; op_neg = 1'b0; op_sel = ACC_NUMY; end
      default: begin op_a = s_fx; op_b = s_xe; op_neg = 1'b1; op_sel = ACC_NUMY; end
    endcase
    a_mag  = op_a[STEN_W-1] ? STEN_W'(-op_a) : STEN_W'(op_a);
    b_mag  = op_b[STEN_W-1] ? STEN_W'(-op_b) : STEN_W'(op_b);
    b_part = ms[0] ? HALF_W'(b_mag[STEN_W-1:HALF_W]) : b_mag[HALF_W-1:0];
  end

  // partial product register
  logic              pp_valid;
  logic [PP_W-1:0]   pp;
  logic              pp_hi;
  logic              pp_sub;
  acc_sel_t          pp_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= (state == S_MUL) && (ms < 4'd12);
    end
  end

  always_ff @(posedge clk) begin
    pp     <= PP_W'(a_mag) * PP_W'(b_part);
    pp_hi  <= ms[0];
    pp_sub <= op_a[STEN_W-1] ^ op_b[STEN_W-1] ^ op_neg;
    pp_sel <= op_sel;
  end

  // signed accumulation of determinant and numerators
  logic signed [ACC_W-1:0] det, numx, numy;
  logic [ACC_W-1:0]        term;
  logic signed [ACC_W-1:0] acc_in;
  logic signed [ACC_W-1:0] acc_out;

  assign term = pp_hi ? (ACC_W'(pp) << HALF_W) : ACC_W'(pp);

  always_comb begin
    case (pp_sel)
      ACC_DET:  acc_in = det;
      ACC_NUMX: acc_in = numx;
      default:  acc_in = numy;
    endcase
    acc_out = pp_sub ? (acc_in - $signed(term)) : (acc_in + $signed(term));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      det  <= '0;
      numx <= '0;
      numy <= '0;
    end else if (pp_valid) begin
      case (pp_sel)
        ACC_DET:  det  <= acc_out;
        ACC_NUMX: numx <= acc_out;
        default:  numy <= acc_out;
      endcase
    end
  end

  // divider
  div_ctl_t                 dctl;
  logic signed [DATA_W-1:0] div_q;

  assign dctl.start = ((state == S_CHECK) && (det != '0)) ||
                      ((state == S_DIVX) && dctl.done);

  cgg_div u_div (
    .clk(clk), .rst(rst), .start(dctl.start),
    .num((state == S_CHECK) ? numx : numy), .den(det),
    .done(dctl.done), .quot(div_q)
  );

  // result holding
  logic signed [DATA_W-1:0] gx, gy;
  logic                     st;
  logic                     out_valid;
  logic                     load;

  assign load = (state == S_DONE) && (!out_valid || rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      t     <= '0;
      ms    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (req.opcode == OP_QUERY)) begin
            state <= S_READ;
            t     <= '0;
          end
        end
        S_READ: begin
          t <= t + 3'd1;
          if (t == 3'd6) begin
            state <= S_MUL;
            ms    <= '0;
          end
        end
        S_MUL: begin
          ms <= ms + 4'd1;
          if (ms == 4'd12) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (det == '0) ? S_DONE : S_DIVX;
        end
        S_DIVX: begin
          if (dctl.done) begin
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (dctl.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // query index saturation and result capture
  always_ff @(posedge clk) begin
    if (accept) begin
      r_q <= (req.row > ny) ? ny : req.row;
      c_q <= (req.col > nx) ? nx : req.col;
    end
    if (state == S_CHECK && det == '0) begin
      gx <= '0;
      gy <= '0;
      st <= ST_SINGULAR;
    end else if (state == S_DIVX && dctl.done) begin
      gx <= div_q;
      st <= ST_OK;
    end else if (state == S_DIVY && dctl.done) begin
      gy <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.grad_x <= gx;
      rsp.grad_y <= gy;
      rsp.status <= st;
    end
  end

  assign rsp.valid = out_valid;
endmodule

[sv/cgg_checker.sv]
// port level checks for the gradient block, bound to the top level
module cgg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_opcode,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [cgg_pkg::DATA_W-1:0]  grad_x,
  input logic signed [cgg_pkg::DATA_W-1:0]  grad_y,
  input logic                               status
);
  import cgg_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(grad_y) &&
    $stable(status))
    else $error("result changed while stalled");

  // a query makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode == OP_QUERY) |=> !in_ready)
    else $error("ready after query transaction");

  // a new result never follows an accepted transaction directly
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too soon after transaction");

  // singular status comes with zero gradients
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_SINGULAR) |-> (grad_x == '0) && (grad_y == '0))
    else $error("singular result not zero");
endmodule

bind curvilinear_grid_gradient cgg_checker u_cgg_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready), .in_opcode(req.opcode),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .grad_x(rsp.grad_x), .grad_y(rsp.grad_y), .status(rsp.status)
);

[sim/tb.sv]
// self-checking testbench for the curvilinear grid gradient block
`timescale 1ns / 1ps

module tb;
  import cgg_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [DATA_W-1:0] grad_x;
    logic signed [DATA_W-1:0] grad_y;
    logic status;
  } gradient_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [CFG_W-1:0] wr_data;

  cgg_req_if req ();
  cgg_rsp_if rsp ();

  curvilinear_grid_gradient DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // mirror of the grid and the interval registers
  logic signed [DATA_W-1:0] x_grid [DEPTH];
  logic signed [DATA_W-1:0] y_grid [DEPTH];
  logic signed [DATA_W-1:0] u_grid [DEPTH];
  bit written [DEPTH];
  logic [CFG_W-1:0] col_cfg;
  logic [CFG_W-1:0] row_cfg;

  gradient_t pending_grads[$];
  int errors;
  int n_writes;
  int n_queries;
  int n_singular;
  int n_checked;
  int n_items;
  int cycles;
  bit quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // grid entry by store select: 0 x, 1 y, 2 field
  function automatic logic signed [63:0] grid_at(int sel, int k);
    logic signed [63:0] v;
    case (sel)
      0: v = 64'(x_grid[k]);
      1: v = 64'(y_grid[k]);
      default: v = 64'(u_grid[k]);
    endcase
    return v;
  endfunction

  // raw difference sum along one axis, common 1/(2h) left out
  function automatic logic signed [63:0] axis_diff(int sel, int r, int c, bit along_xi, int n);
    int pos;
    int st;
    int b;
    pos = along_xi ? c : r;
    st = along_xi ? 1 : MAX_COLS;
    b = r * MAX_COLS + c;
    if (pos == 0)
      return -3 * grid_at(sel, b) + 4 * grid_at(sel, b + st) - grid_at(sel, b + 2 * st);
    if (pos == n)
      return 3 * grid_at(sel, b) - 4 * grid_at(sel, b - st) + grid_at(sel, b - 2 * st);
    return grid_at(sel, b + st) - grid_at(sel, b - st);
  endfunction

  // num/den in Q16.16, rounded half away from zero, saturated
  function automatic logic signed [DATA_W-1:0] q16_quotient(logic signed [127:0] num,
                                                             logic signed [127:0] den);
    logic neg;
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] lim;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    n = n << FRAC_W;
    q = n / d;
    rem = n % d;
    if ((rem << 1) >= d) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -DATA_W'(q) : DATA_W'(q);
  endfunction

  function automatic int clamp_intervals(logic [CFG_W-1:0] v, int maxn);
    if (v < 2) return 2;
    if (int'(v) > maxn) return maxn;
    return int'(v);
  endfunction

  // expected gradient at a grid point through the jacobian
  function automatic gradient_t gradient_at(int r, int c);
    gradient_t g;
    int nx;
    int ny;
    logic signed [127:0] uxi, ueta, xxi, xeta, yxi, yeta, det;
    nx = clamp_intervals(col_cfg, MAX_COLS - 1);
    ny = clamp_intervals(row_cfg, MAX_ROWS - 1);
    if (c > nx) c = nx;
    if (r > ny) r = ny;
    uxi = axis_diff(2, r, c, 1'b1, nx);
    ueta = axis_diff(2, r, c, 1'b0, ny);
    xxi = axis_diff(0, r, c, 1'b1, nx);
    xeta = axis_diff(0, r, c, 1'b0, ny);
    yxi = axis_diff(1, r, c, 1'b1, nx);
    yeta = axis_diff(1, r, c, 1'b0, ny);
    det = xxi * yeta - yxi * xeta;
    g.grad_x = '0;
    g.grad_y = '0;
    g.status = ST_OK;
    if (det == 0) begin
      g.status = ST_SINGULAR;
    end else begin
      g.grad_x = q16_quotient(uxi * yeta - ueta * yxi, det);
      g.grad_y = q16_quotient(ueta * xxi - uxi * xeta, det);
    end
    return g;
  endfunction

  // one request transaction, then an optional idle burst
  task automatic send_item(logic op, int r, int c, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] u);
    int k;
    req.valid <= 1'b1;
    req.opcode <= op;
    req.row <= IDX_W'(r);
    req.col <= IDX_W'(c);
    req.coord_x <= x;
    req.coord_y <= y;
    req.sample <= u;
    do @(posedge clk); while (!req.ready);
    n_items++;
    if (op == OP_WRITE) begin
      k = r * MAX_COLS + c;
      x_grid[k] = x;
      y_grid[k] = y;
      u_grid[k] = u;
      written[k] = 1'b1;
      n_writes++;
    end else begin
      pending_grads.push_back(gradient_at(r, c));
      n_queries++;
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic set_intervals(logic [CFG_W-1:0] ncol, logic [CFG_W-1:0] nrow);
    wr_en <= 1'b1;
    wr_index <= REG_COL_INTERVALS;
    wr_data <= ncol;
    @(posedge clk);
    wr_index <= REG_ROW_INTERVALS;
    wr_data <= nrow;
    @(posedge clk);
    wr_en <= 1'b0;
    col_cfg = ncol;
    row_cfg = nrow;
    @(posedge clk);
  endtask

  // well-formed point: sheared grid with small jitter
  task automatic write_grid_point(int r, int c);
    logic signed [31:0] x;
    logic signed [31:0] y;
    x = (c <<< 16) + (r <<< 13) + $signed($urandom_range(0, 16'h3fff)) - 32'sh2000;
    y = (r <<< 16) - (c <<< 12) + $signed($urandom_range(0, 16'h3fff)) - 32'sh2000;
    send_item(OP_WRITE, r, c, x, y, $urandom_range(0, 1) ? $urandom : $urandom >>> 12);
  endtask

  // fill one entry with a well-formed point if it was never written
  task automatic ensure_entry(int r, int c);
    if (!written[r * MAX_COLS + c]) write_grid_point(r, c);
  endtask

  // query a point after every entry its stencils touch has been written
  task automatic query_point(int r, int c);
    int nx;
    int ny;
    int rq;
    int cq;
    int p0;
    nx = clamp_intervals(col_cfg, MAX_COLS - 1);
    ny = clamp_intervals(row_cfg, MAX_ROWS - 1);
    rq = (r > ny) ? ny : r;
    cq = (c > nx) ? nx : c;
    p0 = (cq == 0) ? 0 : ((cq == nx) ? nx - 2 : cq - 1);
    for (int i = 0; i < 3; i++) ensure_entry(rq, p0 + i);
    p0 = (rq == 0) ? 0 : ((rq == ny) ? ny - 2 : rq - 1);
    for (int i = 0; i < 3; i++) ensure_entry(p0 + i, cq);
    send_item(OP_QUERY, r, c, 0, 0, 0);
  endtask

  // corners, edges, clamped indices, singular and saturating cases
  task automatic test_directed();
    go_idle();
    set_intervals(CFG_W'(2), CFG_W'(2));
    query_point(0, 0);
    query_point(2, 2);
    query_point(1, 1);
    query_point(0, 2);
    query_point(63, 63);
    // flat x in the corner block gives a zero determinant
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(OP_WRITE, r, c, 32'sh7fff_ffff, r <<< 16, c);
    query_point(1, 1);
    query_point(0, 0);
    // unit spacing and extreme samples saturate the gradient
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(OP_WRITE, r, c, c, r,
                  ((r + c) % 2) ? 32'sh7fff_ffff : 32'sh8000_0000);
    query_point(1, 1);
    query_point(2, 0);
    send_item(OP_WRITE, 1, 1, 32'sh8000_0000, 32'sh8000_0000, 0);
    query_point(1, 1);
    query_point(0, 1);
    go_idle();
    // intervals below 2 act as 2
    set_intervals(CFG_W'(0), CFG_W'(1));
    query_point(5, 7);
    query_point(2, 2);
    go_idle();
    set_intervals(CFG_W'(63), CFG_W'(63));
    query_point(63, 0);
    query_point(0, 63);
    query_point(31, 32);
  endtask

  // random phase: mostly well-formed writes and queries, some raw noise
  task automatic test_random_phase(logic [CFG_W-1:0] ncol, logic [CFG_W-1:0] nrow,
                                   int count, bit last);
    int sel;
    int start;
    go_idle();
    set_intervals(ncol, nrow);
    start = n_items;
    while (n_items - start < count) begin
      if (last && (n_items - start) > count / 2) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if ($urandom_range(0, 4) == 0)
          query_point($urandom_range(0, 63), $urandom_range(0, 63));
        else
          query_point($urandom_range(0, clamp_intervals(nrow, MAX_ROWS - 1)),
                      $urandom_range(0, clamp_intervals(ncol, MAX_COLS - 1)));
      end else if (sel < 88) begin
        write_grid_point($urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        send_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom, $urandom, $urandom);
      end
    end
  endtask

  // response ready with random stall bursts
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // compare each gradient transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grads.size() == 0) begin
        $display("%0t unexpected result: grad_x %h grad_y %h status %b",
                 $time, rsp.grad_x, rsp.grad_y, rsp.status);
        errors++;
      end else begin
        gradient_t g;
        g = pending_grads.pop_front();
        n_checked++;
        if (g.status == ST_SINGULAR) n_singular++;
        if (rsp.grad_x !== g.grad_x) begin
          $display("%0t grad_x mismatch: expected %h actual %h", $time, g.grad_x, rsp.grad_x);
          errors++;
        end
        if (rsp.grad_y !== g.grad_y) begin
          $display("%0t grad_y mismatch: expected %h actual %h", $time, g.grad_y, rsp.grad_y);
          errors++;
        end
        if (rsp.status !== g.status) begin
          $display("%0t status mismatch: expected %b actual %b", $time, g.status, rsp.status);
          errors++;
        end
      end
    end
  end

  // test sequence
  initial begin
    errors = 0;
    n_writes = 0;
    n_queries = 0;
    n_singular = 0;
    n_checked = 0;
    n_items = 0;
    cycles = 0;
    quiet = 1'b0;
    col_cfg = CFG_W'(63);
    row_cfg = CFG_W'(63);
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_COL_INTERVALS;
    wr_data <= '0;
    req.valid <= 1'b0;
    req.opcode <= OP_WRITE;
    req.row <= '0;
    req.col <= '0;
    req.coord_x <= '0;
    req.coord_y <= '0;
    req.sample <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(CFG_W'(63), CFG_W'(63), 280, 1'b0);
    test_random_phase(CFG_W'($urandom_range(2, 62)), CFG_W'($urandom_range(2, 62)), 280, 1'b0);
    test_random_phase(CFG_W'(1), CFG_W'(0), 140, 1'b0);
    test_random_phase(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)), 420, 1'b1);

    go_idle();
    $display("covered %0d writes and %0d queries, %0d results checked, %0d singular",
             n_writes, n_queries, n_checked, n_singular);
    $display("interval settings from below the minimum up to 63, clamped indices included");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
